FILE: hw/rtl/jittered_relay_slot_scheduler_macros.svh
// assertion helpers for the checker of the relay slot scheduler
`ifndef JITTERED_RELAY_SLOT_SCHEDULER_MACROS_SVH
`define JITTERED_RELAY_SLOT_SCHEDULER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define JRSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jrss check failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define JRSS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jrss check failed");

`endif

FILE: hw/rtl/jrss_pkg.sv
`timescale 1ns / 1ps

package jrss_pkg;

    // table size default
    localparam int SLOT_COUNT_DEF = 8;

    // field widths
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int REF_W     = 8;
    localparam int LEN_W     = 8;
    localparam int KIND_W    = 2;
    localparam int OUT_IDX_W = 3;
    localparam int TOTAL_W   = 32;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_JITTER_MIN = 1'b0;
    localparam logic REG_JITTER_MAX = 1'b1;
    localparam logic [CFG_W-1:0] JITTER_MIN_RST = 16'd10;
    localparam logic [CFG_W-1:0] JITTER_MAX_RST = 16'd50;

    // remainder unit: one quotient bit per cycle
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // input action codes
    localparam logic ACT_QUEUE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_QUEUED  = 2'd0,
        KIND_DROPPED = 2'd1,
        KIND_RELAY   = 2'd2,
        KIND_DONE    = 2'd3
    } t_kind;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QFIND,
        ST_MOD,
        ST_QWRITE,
        ST_DROP,
        ST_SCAN,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

FILE: hw/rtl/jrss_mod.sv
`timescale 1ns / 1ps

module jrss_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [jrss_pkg::TIME_W-1:0]   i_dividend,
    input  logic [jrss_pkg::TIME_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [jrss_pkg::TIME_W-1:0]   o_remainder
);

    logic                            r_busy;
    logic                            r_done;
    logic [jrss_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [jrss_pkg::TIME_W-1:0]     r_dvd;
    logic [jrss_pkg::TIME_W-1:0]     r_dvs;
    logic [jrss_pkg::TIME_W-1:0]     r_rem;

    logic [jrss_pkg::TIME_W:0]       rem_sh;
    logic [jrss_pkg::TIME_W:0]       rem_sub;
    logic                            rem_ge;
    logic [jrss_pkg::TIME_W-1:0]     n_rem;

    // restoring step: shift in next dividend bit, subtract when it fits
    always_comb begin
        rem_sh  = {r_rem, r_dvd[jrss_pkg::TIME_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        rem_ge  = (rem_sh >= {1'b0, r_dvs});
        n_rem   = rem_ge ? rem_sub[jrss_pkg::TIME_W-1:0] : rem_sh[jrss_pkg::TIME_W-1:0];
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == jrss_pkg::DIV_CNT_W'(jrss_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[jrss_pkg::TIME_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

FILE: hw/rtl/jittered_relay_slot_scheduler.sv
`timescale 1ns / 1ps
// channel  | direction | handshake                  | payload
// input    | in        | i_in_valid / o_in_ready    | action, now_ms, random_word, frame_ref/len
// result   | out       | o_out_valid / i_out_ready  | kind, slot_index, frame ref/len, totals, last
// config   | in        | psel, penable, pwrite, ... | jitter_min_ms at 0x0, jitter_max_ms at 0x4
//
// one item at a time; a queue runs the slot search, 32 steps of the bit-serial
// remainder unit and the table write, and skips the remainder unit when the jitter
// window wraps to 2^32; a drop only loads its result; a tick steps over every
// slot, one slot table read per step through the single read port of the slot memory
// reset clears the busy flags and counters at once; no clearing pass
// a stalled result holds in the output register and the sequencer waits on it

module jittered_relay_slot_scheduler #(
    parameter int SLOT_COUNT = jrss_pkg::SLOT_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_action,
    input  logic [jrss_pkg::TIME_W-1:0]        i_now_ms,
    input  logic [jrss_pkg::TIME_W-1:0]        i_random_word,
    input  logic [jrss_pkg::REF_W-1:0]         i_frame_ref,
    input  logic [jrss_pkg::LEN_W-1:0]         i_frame_len,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [jrss_pkg::KIND_W-1:0]        o_kind,
    output logic [jrss_pkg::OUT_IDX_W-1:0]     o_slot_index,
    output logic [jrss_pkg::REF_W-1:0]         o_out_frame_ref,
    output logic [jrss_pkg::LEN_W-1:0]         o_out_frame_len,
    output logic [jrss_pkg::TOTAL_W-1:0]       o_relayed_total,
    output logic [jrss_pkg::TOTAL_W-1:0]       o_full_drops_total,
    output logic                               o_last,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [jrss_pkg::PADDR_W-1:0]       paddr,
    input  logic [jrss_pkg::PDATA_W-1:0]       pwdata,
    output logic [jrss_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SCAN_W = $clog2(SLOT_COUNT + 1);
    localparam int ENT_W  = jrss_pkg::TIME_W + jrss_pkg::REF_W + jrss_pkg::LEN_W;
    localparam int PAD_W  = jrss_pkg::TIME_W - jrss_pkg::CFG_W;

    // state
    jrss_pkg::t_state                  r_state, n_state;
    logic [jrss_pkg::CFG_W-1:0]        r_jit_min;
    logic [jrss_pkg::CFG_W-1:0]        r_jit_max;
    logic [SLOT_COUNT-1:0]             r_busy;
    logic [jrss_pkg::TOTAL_W-1:0]      r_relayed;
    logic [jrss_pkg::TOTAL_W-1:0]      r_drops;
    logic [SCAN_W-1:0]                 r_scan;
    logic [IDX_W-1:0]                  r_slot;
    logic [jrss_pkg::TIME_W-1:0]       r_jit;
    logic [jrss_pkg::TIME_W-1:0]       r_now;
    logic [jrss_pkg::TIME_W-1:0]       r_rnd;
    logic [jrss_pkg::REF_W-1:0]        r_ref;
    logic [jrss_pkg::LEN_W-1:0]        r_len;

    // slot memory
    logic [ENT_W-1:0]                  r_mem [SLOT_COUNT];
    logic [ENT_W-1:0]                  r_rd_data;

    // output register
    logic                              r_out_valid;
    jrss_pkg::t_kind                   r_kind;
    logic [IDX_W-1:0]                  r_oidx;
    logic [jrss_pkg::REF_W-1:0]        r_oref;
    logic [jrss_pkg::LEN_W-1:0]        r_olen;
    logic [jrss_pkg::TOTAL_W-1:0]      r_orel;
    logic [jrss_pkg::TOTAL_W-1:0]      r_odrop;
    logic                              r_olast;

    // combinational
    logic                              take_in;
    logic                              cfg_wr;
    logic                              free_found;
    logic [IDX_W-1:0]                  free_idx;
    logic [IDX_W-1:0]                  scan_idx;
    logic                              scan_end;
    logic [jrss_pkg::TIME_W-1:0]       span;
    logic [jrss_pkg::TIME_W-1:0]       due;
    logic [jrss_pkg::TIME_W-1:0]       rd_due;
    logic [jrss_pkg::REF_W-1:0]        rd_ref;
    logic [jrss_pkg::LEN_W-1:0]        rd_len;
    logic [jrss_pkg::TIME_W-1:0]       age;
    logic                              out_free;
    logic                              mod_start;
    logic                              mod_done;
    logic [jrss_pkg::TIME_W-1:0]       mod_rem;
    logic                              mem_we;
    logic                              busy_set;
    logic                              busy_clr;
    logic                              rel_inc;
    logic                              drop_inc;
    logic                              scan_inc;
    logic                              out_load;
    jrss_pkg::t_kind                   out_kind;
    logic [IDX_W-1:0]                  out_idx;
    logic [jrss_pkg::REF_W-1:0]        out_ref;
    logic [jrss_pkg::LEN_W-1:0]        out_len;
    logic                              out_last;
    logic [IDX_W+2:0]                  oidx_ext;

    assign take_in  = i_in_valid && o_in_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_valid || i_out_ready;
    assign scan_idx = r_scan[IDX_W-1:0];
    assign scan_end = (r_scan == SCAN_W'(SLOT_COUNT));

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // jitter window and due time, both modulo 2^32
    assign span = {{PAD_W{1'b0}}, r_jit_max} - {{PAD_W{1'b0}}, r_jit_min} + 32'd1;
    assign due  = r_now + {{PAD_W{1'b0}}, r_jit_min} + r_jit;

    // stored entry fields and wrap-aware age
    assign {rd_due, rd_ref, rd_len} = r_rd_data;
    assign age = r_now - rd_due;

    // random word modulo window
    jrss_mod u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (mod_start),
        .i_dividend  (r_rnd),
        .i_divisor   (span),
        .o_done      (mod_done),
        .o_remainder (mod_rem)
    );

    // sequencer next state and strobes
    always_comb begin
        n_state   = r_state;
        mod_start = 1'b0;
        mem_we    = 1'b0;
        busy_set  = 1'b0;
        busy_clr  = 1'b0;
        rel_inc   = 1'b0;
        drop_inc  = 1'b0;
        scan_inc  = 1'b0;
        out_load  = 1'b0;
        out_kind  = jrss_pkg::KIND_DONE;
        out_idx   = '0;
        out_ref   = '0;
        out_len   = '0;
        out_last  = 1'b1;
        unique case (r_state)
            jrss_pkg::ST_IDLE: begin
                if (take_in) begin
                    n_state = (i_action == jrss_pkg::ACT_TICK) ? jrss_pkg::ST_SCAN
                                                               : jrss_pkg::ST_QFIND;
                end
            end
            jrss_pkg::ST_QFIND: begin
                if (!free_found) begin
                    n_state = jrss_pkg::ST_DROP;
                end else if (span == '0) begin
                    n_state = jrss_pkg::ST_QWRITE;
                end else begin
                    mod_start = 1'b1;
                    n_state   = jrss_pkg::ST_MOD;
                end
            end
            jrss_pkg::ST_MOD: begin
                if (mod_done) begin
                    n_state = jrss_pkg::ST_QWRITE;
                end
            end
            jrss_pkg::ST_QWRITE: begin
                if (out_free) begin
                    mem_we   = 1'b1;
                    busy_set = 1'b1;
                    out_load = 1'b1;
                    out_kind = jrss_pkg::KIND_QUEUED;
                    out_idx  = r_slot;
                    out_ref  = r_ref;
                    out_len  = r_len;
                    n_state  = jrss_pkg::ST_IDLE;
                end
            end
            jrss_pkg::ST_DROP: begin
                if (out_free) begin
                    drop_inc = 1'b1;
                    out_load = 1'b1;
                    out_kind = jrss_pkg::KIND_DROPPED;
                    n_state  = jrss_pkg::ST_IDLE;
                end
            end
            jrss_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = jrss_pkg::ST_DONE;
                end else if (r_busy[scan_idx]) begin
                    n_state = jrss_pkg::ST_READ;
                end else begin
                    scan_inc = 1'b1;
                end
            end
            jrss_pkg::ST_READ: begin
                if (age[jrss_pkg::TIME_W-1]) begin
                    scan_inc = 1'b1;
                    n_state  = jrss_pkg::ST_SCAN;
                end else if (out_free) begin
                    busy_clr = 1'b1;
                    rel_inc  = 1'b1;
                    scan_inc = 1'b1;
                    out_load = 1'b1;
                    out_kind = jrss_pkg::KIND_RELAY;
                    out_idx  = scan_idx;
                    out_ref  = rd_ref;
                    out_len  = rd_len;
                    out_last = 1'b0;
                    n_state  = jrss_pkg::ST_SCAN;
                end
            end
            jrss_pkg::ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = jrss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jrss_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jrss_pkg::ST_IDLE;
            r_jit_min   <= jrss_pkg::JITTER_MIN_RST;
            r_jit_max   <= jrss_pkg::JITTER_MAX_RST;
            r_busy      <= '0;
            r_relayed   <= '0;
            r_drops     <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                if (paddr[2] == jrss_pkg::REG_JITTER_MAX) begin
                    r_jit_max <= pwdata[jrss_pkg::CFG_W-1:0];
                end else begin
                    r_jit_min <= pwdata[jrss_pkg::CFG_W-1:0];
                end
            end
            if (busy_set) begin
                r_busy[r_slot] <= 1'b1;
            end
            if (busy_clr) begin
                r_busy[scan_idx] <= 1'b0;
            end
            if (rel_inc) begin
                r_relayed <= r_relayed + 1'b1;
            end
            if (drop_inc) begin
                r_drops <= r_drops + 1'b1;
            end
            if (take_in) begin
                r_scan <= '0;
            end else if (scan_inc) begin
                r_scan <= r_scan + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and working registers
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_now <= i_now_ms;
            r_rnd <= i_random_word;
            r_ref <= i_frame_ref;
            r_len <= i_frame_len;
        end
        if (r_state == jrss_pkg::ST_QFIND) begin
            r_slot <= free_idx;
            r_jit  <= r_rnd;
        end else if (mod_done) begin
            r_jit <= mod_rem;
        end
    end

    // slot memory: one write port, one registered read port at the scan slot
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= {due, r_ref, r_len};
        end
        r_rd_data <= r_mem[scan_idx];
    end

    // result register, totals taken after this result's count
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_kind  <= out_kind;
            r_oidx  <= out_idx;
            r_oref  <= out_ref;
            r_olen  <= out_len;
            r_olast <= out_last;
            r_orel  <= r_relayed + jrss_pkg::TOTAL_W'(rel_inc);
            r_odrop <= r_drops + jrss_pkg::TOTAL_W'(drop_inc);
        end
    end

    // ports
    assign o_in_ready         = (r_state == jrss_pkg::ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_kind;
    assign oidx_ext           = {3'b000, r_oidx};
    assign o_slot_index       = oidx_ext[jrss_pkg::OUT_IDX_W-1:0];
    assign o_out_frame_ref    = r_oref;
    assign o_out_frame_len    = r_olen;
    assign o_relayed_total    = r_orel;
    assign o_full_drops_total = r_odrop;
    assign o_last             = r_olast;

    // register read back
    assign prdata = (paddr[2] == jrss_pkg::REG_JITTER_MAX) ? {{PAD_W{1'b0}}, r_jit_max}
                                                           : {{PAD_W{1'b0}}, r_jit_min};
    assign pready = 1'b1;

endmodule

FILE: hw/rtl/jrss_checker.sv
`timescale 1ns / 1ps
`include "jittered_relay_slot_scheduler_macros.svh"

module jrss_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [jrss_pkg::KIND_W-1:0]        o_kind,
    input logic [jrss_pkg::OUT_IDX_W-1:0]     o_slot_index,
    input logic [jrss_pkg::REF_W-1:0]         o_out_frame_ref,
    input logic [jrss_pkg::LEN_W-1:0]         o_out_frame_len,
    input logic [jrss_pkg::TOTAL_W-1:0]       o_relayed_total,
    input logic [jrss_pkg::TOTAL_W-1:0]       o_full_drops_total,
    input logic                               o_last
);

    // a stalled result stays valid with its kind, slot, last flag and totals held still
    `JRSS_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_kind) && $stable(o_slot_index) && $stable(o_last) && $stable(o_relayed_total) && $stable(o_full_drops_total))

    // a relay is never the final result, every other kind is
    `JRSS_ASSERT_IMP(a_last_kind, o_out_valid, o_last == (o_kind != jrss_pkg::KIND_RELAY))

    // done and drop results carry no slot or frame
    `JRSS_ASSERT_IMP(a_empty_fields, o_out_valid && (o_kind == jrss_pkg::KIND_DONE || o_kind == jrss_pkg::KIND_DROPPED), o_slot_index == '0 && o_out_frame_ref == '0 && o_out_frame_len == '0)

    // no new item is taken while a non-final result still waits
    `JRSS_ASSERT_IMP(a_no_take_mid_item, o_out_valid && !o_last, !o_in_ready)

endmodule

bind jittered_relay_slot_scheduler jrss_checker u_jrss_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_kind             (o_kind),
    .o_slot_index       (o_slot_index),
    .o_out_frame_ref    (o_out_frame_ref),
    .o_out_frame_len    (o_out_frame_len),
    .o_relayed_total    (o_relayed_total),
    .o_full_drops_total (o_full_drops_total),
    .o_last             (o_last)
);

FILE: bench/jittered_relay_slot_scheduler_tb.sv
`timescale 1ns / 1ps

module jittered_relay_slot_scheduler_tb;

    localparam int SLOTS         = jrss_pkg::SLOT_COUNT_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int END_CYCLES    = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 500000;

    localparam logic [jrss_pkg::PADDR_W-1:0] ADDR_MIN = {jrss_pkg::REG_JITTER_MIN, 2'b00};
    localparam logic [jrss_pkg::PADDR_W-1:0] ADDR_MAX = {jrss_pkg::REG_JITTER_MAX, 2'b00};

    // one expected result transfer
    typedef struct {
        jrss_pkg::t_kind                kind;
        logic [jrss_pkg::OUT_IDX_W-1:0] slot;
        logic [jrss_pkg::REF_W-1:0]     fref;
        logic [jrss_pkg::LEN_W-1:0]     flen;
        logic [jrss_pkg::TOTAL_W-1:0]   relayed;
        logic [jrss_pkg::TOTAL_W-1:0]   drops;
        logic                           is_last;
    } t_relay_result;

    // slot table predictor and queue of awaited results
    class relay_slot_board;
        logic [jrss_pkg::CFG_W-1:0]   jit_min;
        logic [jrss_pkg::CFG_W-1:0]   jit_max;
        logic                         busy [SLOTS];
        logic [jrss_pkg::TIME_W-1:0]  due_at [SLOTS];
        logic [jrss_pkg::REF_W-1:0]   held_ref [SLOTS];
        logic [jrss_pkg::LEN_W-1:0]   held_len [SLOTS];
        logic [jrss_pkg::TOTAL_W-1:0] relayed;
        logic [jrss_pkg::TOTAL_W-1:0] drops;
        t_relay_result                awaited_results[$];
        int                           mismatches;

        function new();
            jit_min = jrss_pkg::JITTER_MIN_RST;
            jit_max = jrss_pkg::JITTER_MAX_RST;
            foreach (busy[i]) begin
                busy[i] = 1'b0;
                due_at[i] = '0;
                held_ref[i] = '0;
                held_len[i] = '0;
            end
            relayed = '0;
            drops = '0;
            mismatches = 0;
        endfunction

        function void set_register(logic sel, logic [jrss_pkg::CFG_W-1:0] value);
            if (sel == jrss_pkg::REG_JITTER_MIN) begin
                jit_min = value;
            end else begin
                jit_max = value;
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        function void add_result(jrss_pkg::t_kind k, int slot, logic [jrss_pkg::REF_W-1:0] fr,
                                 logic [jrss_pkg::LEN_W-1:0] fl, logic lst);
            t_relay_result r;
            r.kind = k;
            r.slot = jrss_pkg::OUT_IDX_W'(slot);
            r.fref = fr;
            r.flen = fl;
            r.relayed = relayed;
            r.drops = drops;
            r.is_last = lst;
            awaited_results.push_back(r);
        endfunction

        // work out the results of one accepted input transfer
        function void note_item(logic act, logic [jrss_pkg::TIME_W-1:0] now,
                                logic [jrss_pkg::TIME_W-1:0] rnd,
                                logic [jrss_pkg::REF_W-1:0] fr,
                                logic [jrss_pkg::LEN_W-1:0] fl);
            logic [jrss_pkg::TIME_W-1:0] span;
            logic [jrss_pkg::TIME_W-1:0] jit;
            logic [jrss_pkg::TIME_W-1:0] diff;
            bit                          placed;
            int                          i;
            placed = 1'b0;
            if (act == jrss_pkg::ACT_QUEUE) begin
                for (i = 0; i < SLOTS; i++) begin
                    if (!placed && !busy[i]) begin
                        // window size wraps to zero when max is one below min
                        span = {16'd0, jit_max} - {16'd0, jit_min} + 32'd1;
                        jit = (span == '0) ? rnd : (rnd % span);
                        due_at[i] = now + {16'd0, jit_min} + jit;
                        held_ref[i] = fr;
                        held_len[i] = fl;
                        busy[i] = 1'b1;
                        placed = 1'b1;
                        add_result(jrss_pkg::KIND_QUEUED, i, fr, fl, 1'b1);
                    end
                end
                if (!placed) begin
                    drops = drops + 1;
                    add_result(jrss_pkg::KIND_DROPPED, 0, '0, '0, 1'b1);
                end
            end else begin
                for (i = 0; i < SLOTS; i++) begin
                    if (busy[i]) begin
                        diff = now - due_at[i];
                        if (!diff[jrss_pkg::TIME_W-1]) begin
                            busy[i] = 1'b0;
                            relayed = relayed + 1;
                            add_result(jrss_pkg::KIND_RELAY, i, held_ref[i], held_len[i],
                                       1'b0);
                        end
                    end
                end
                add_result(jrss_pkg::KIND_DONE, 0, '0, '0, 1'b1);
            end
        endfunction

        // compare one result transfer with the oldest awaited one
        task check_result(logic [jrss_pkg::KIND_W-1:0] k,
                          logic [jrss_pkg::OUT_IDX_W-1:0] slot,
                          logic [jrss_pkg::REF_W-1:0] fr, logic [jrss_pkg::LEN_W-1:0] fl,
                          logic [jrss_pkg::TOTAL_W-1:0] rel,
                          logic [jrss_pkg::TOTAL_W-1:0] drp, logic lst);
            t_relay_result w;
            if (awaited_results.size() == 0) begin
                report($sformatf("result with nothing awaited, kind %0d", k));
            end else begin
                w = awaited_results.pop_front();
                if (k !== w.kind)
                    report($sformatf("kind got %0d want %0d", k, w.kind));
                if (slot !== w.slot)
                    report($sformatf("slot_index got %0d want %0d", slot, w.slot));
                if (fr !== w.fref)
                    report($sformatf("frame_ref got %0d want %0d", fr, w.fref));
                if (fl !== w.flen)
                    report($sformatf("frame_len got %0d want %0d", fl, w.flen));
                if (rel !== w.relayed)
                    report($sformatf("relayed_total got %0d want %0d", rel, w.relayed));
                if (drp !== w.drops)
                    report($sformatf("full_drops_total got %0d want %0d", drp, w.drops));
                if (lst !== w.is_last)
                    report($sformatf("last got %0d want %0d", lst, w.is_last));
            end
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic                           i_action;
    logic [jrss_pkg::TIME_W-1:0]    i_now_ms;
    logic [jrss_pkg::TIME_W-1:0]    i_random_word;
    logic [jrss_pkg::REF_W-1:0]     i_frame_ref;
    logic [jrss_pkg::LEN_W-1:0]     i_frame_len;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [jrss_pkg::KIND_W-1:0]    o_kind;
    logic [jrss_pkg::OUT_IDX_W-1:0] o_slot_index;
    logic [jrss_pkg::REF_W-1:0]     o_out_frame_ref;
    logic [jrss_pkg::LEN_W-1:0]     o_out_frame_len;
    logic [jrss_pkg::TOTAL_W-1:0]   o_relayed_total;
    logic [jrss_pkg::TOTAL_W-1:0]   o_full_drops_total;
    logic                           o_last;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [jrss_pkg::PADDR_W-1:0]   paddr;
    logic [jrss_pkg::PDATA_W-1:0]   pwdata;
    logic [jrss_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    relay_slot_board board;
    bit              quiet;
    int              hold_asked;
    int              cycle_count;

    jittered_relay_slot_scheduler #(.SLOT_COUNT(SLOTS)) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_now_ms           (i_now_ms),
        .i_random_word      (i_random_word),
        .i_frame_ref        (i_frame_ref),
        .i_frame_len        (i_frame_len),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_kind             (o_kind),
        .o_slot_index       (o_slot_index),
        .o_out_frame_ref    (o_out_frame_ref),
        .o_out_frame_len    (o_out_frame_len),
        .o_relayed_total    (o_relayed_total),
        .o_full_drops_total (o_full_drops_total),
        .o_last             (o_last),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(o_kind, o_slot_index, o_out_frame_ref, o_out_frame_len,
                               o_relayed_total, o_full_drops_total, o_last);
        end
    end

    // result receiver with random stalls and one long hold-off on request
    initial begin : receiver
        int hold_done;
        hold_done = 0;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_done < hold_asked) begin
                hold_done++;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    // one input transfer, starting and ending at a falling edge
    task send_item(logic act, logic [jrss_pkg::TIME_W-1:0] now,
                   logic [jrss_pkg::TIME_W-1:0] rnd,
                   logic [jrss_pkg::REF_W-1:0] fr, logic [jrss_pkg::LEN_W-1:0] fl);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_action = act;
        i_now_ms = now;
        i_random_word = rnd;
        i_frame_ref = fr;
        i_frame_len = fl;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_item(act, now, rnd, fr, fl);
        @(negedge i_clk);
    endtask

    task queue_frame(logic [jrss_pkg::TIME_W-1:0] now, logic [jrss_pkg::TIME_W-1:0] rnd,
                     logic [jrss_pkg::REF_W-1:0] fr, logic [jrss_pkg::LEN_W-1:0] fl);
        send_item(jrss_pkg::ACT_QUEUE, now, rnd, fr, fl);
    endtask

    // tick payload beyond the time is ignored, so it carries noise
    task service_tick(logic [jrss_pkg::TIME_W-1:0] now);
        send_item(jrss_pkg::ACT_TICK, now, $urandom, jrss_pkg::REF_W'($urandom),
                  jrss_pkg::LEN_W'($urandom));
    endtask

    // stop offering and wait until the block has gone quiet
    task drain();
        i_in_valid = 1'b0;
        while (board.awaited_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task apb_write(logic [jrss_pkg::PADDR_W-1:0] addr, logic [jrss_pkg::PDATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_register(addr[2], data[jrss_pkg::CFG_W-1:0]);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task apb_read_check(logic [jrss_pkg::PADDR_W-1:0] addr, logic [jrss_pkg::CFG_W-1:0] want);
        logic [jrss_pkg::PDATA_W-1:0] got;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (got !== {16'd0, want})
            board.report($sformatf("register at %0d read %0d want %0d", addr, got, want));
    endtask

    task set_window(logic [jrss_pkg::CFG_W-1:0] mn, logic [jrss_pkg::CFG_W-1:0] mx);
        drain();
        apb_write(ADDR_MIN, {16'd0, mn});
        apb_write(ADDR_MAX, {16'd0, mx});
        apb_read_check(ADDR_MIN, mn);
        apb_read_check(ADDR_MAX, mx);
    endtask

    // edge cases of fields, table full, due wrap and window wrap
    task run_directed();
        logic [jrss_pkg::TIME_W-1:0] rnd_pick [SLOTS];
        logic [jrss_pkg::REF_W-1:0]  ref_pick [SLOTS];
        int                          i;
        rnd_pick = '{32'h0, 32'hFFFF_FFFF, 32'd40, 32'd41, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
        ref_pick = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'hFE};
        apb_read_check(ADDR_MIN, jrss_pkg::JITTER_MIN_RST);
        apb_read_check(ADDR_MAX, jrss_pkg::JITTER_MAX_RST);
        // empty table tick
        service_tick(32'h0);
        // fill every slot, with due times that mostly wrap past zero
        for (i = 0; i < SLOTS; i++) begin
            queue_frame(32'hFFFF_FFF0, rnd_pick[i], ref_pick[i], ~ref_pick[i]);
        end
        queue_frame(32'hFFFF_FFFF, 32'h1234_5678, 8'hFF, 8'hFF);
        service_tick(32'hFFFF_FFF9);
        service_tick(32'h0000_002C);
        // window of the full 32-bit range
        set_window(16'd1, 16'd0);
        queue_frame(32'h0, 32'h7FFF_FFFF, 8'h3C, 8'hC3);
        service_tick(32'h0000_0001);
        service_tick(32'h8000_0000);
        // inverted window
        set_window(16'hFFFF, 16'h0000);
        queue_frame(32'h1234_5678, 32'hFFFF_FFFF, 8'h11, 8'h22);
        service_tick(32'hFFFF_FFFF);
        // zero delay
        set_window(16'd0, 16'd0);
        queue_frame(32'd5, $urandom, 8'h33, 8'h44);
        service_tick(32'd5);
        // largest fixed delay
        set_window(16'hFFFF, 16'hFFFF);
        queue_frame(32'h0, $urandom, 8'h66, 8'h77);
        service_tick(32'd65534);
        service_tick(32'd65535);
    endtask

    // mostly advancing time with some noise at arbitrary times
    task run_phase(logic [jrss_pkg::CFG_W-1:0] mn, logic [jrss_pkg::CFG_W-1:0] mx, int count,
                   int step_max, int hold_at, int pause_at);
        logic [jrss_pkg::TIME_W-1:0] clock_ms;
        int                          k;
        int                          pick;
        set_window(mn, mx);
        clock_ms = $urandom;
        for (k = 0; k < count; k++) begin
            if (k == hold_at)
                hold_asked++;
            if (k == pause_at)
                drain();
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                service_tick($urandom);
            end else if (pick == 1) begin
                queue_frame($urandom, $urandom, jrss_pkg::REF_W'($urandom),
                            jrss_pkg::LEN_W'($urandom));
            end else begin
                clock_ms = clock_ms + jrss_pkg::TIME_W'($urandom_range(0, step_max));
                if (pick < 10)
                    queue_frame(clock_ms, $urandom, jrss_pkg::REF_W'($urandom),
                                jrss_pkg::LEN_W'($urandom));
                else
                    service_tick(clock_ms);
            end
        end
    endtask

    // main sequence
    initial begin : stimulus
        logic [jrss_pkg::CFG_W-1:0] mn;
        quiet = 1'b0;
        hold_asked = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = jrss_pkg::ACT_QUEUE;
        i_now_ms = '0;
        i_random_word = '0;
        i_frame_ref = '0;
        i_frame_len = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        board = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        run_directed();

        run_phase(jrss_pkg::JITTER_MIN_RST, jrss_pkg::JITTER_MAX_RST, 50, 12, -1, -1);
        run_phase(16'd0, 16'hFFFF, 50, 9000, 10, -1);
        run_phase(16'd300, 16'd20, 45, 40, -1, 20);
        run_phase(16'hFFFF, 16'hFFFE, 40, 50, -1, -1);
        mn = jrss_pkg::CFG_W'($urandom_range(0, 400));
        run_phase(mn, mn + jrss_pkg::CFG_W'($urandom_range(0, 200)), 45, 60, -1, -1);
        mn = jrss_pkg::CFG_W'($urandom_range(0, 400));
        run_phase(mn, mn + jrss_pkg::CFG_W'($urandom_range(0, 200)), 45, 60, -1, -1);
        run_phase(16'd0, 16'd0, 40, 3, -1, -1);
        // no idling on either side from here
        quiet = 1'b1;
        run_phase(16'd5, 16'd40, 40, 10, -1, -1);

        drain();
        repeat (END_CYCLES) @(negedge i_clk);
        if (board.mismatches == 0 && board.awaited_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/jrss_pkg.sv
hw/rtl/jrss_mod.sv
hw/rtl/jittered_relay_slot_scheduler.sv
hw/rtl/jrss_checker.sv
bench/jittered_relay_slot_scheduler_tb.sv
